// ===== src/cdl_pkg.sv =====
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared types and constants of the table mapping and saturation pixel block.
// ----------------------------------------------------------------------------
package cdl_pkg;

  // pixel and table geometry
  localparam int unsigned CompW      = 8;
  localparam int unsigned NumChan    = 4;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned GainW      = 12;

  // stream widths: input fields in tdata padded to whole bytes
  localparam int unsigned InFieldsW = 4 * CompW + ChanW + IndexW + CompW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = 4 * CompW;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // rec.709 luma weights, q0.16, summing to one
  localparam logic [15:0] WeightRed   = 16'd13933;
  localparam logic [15:0] WeightGreen = 16'd46871;
  localparam logic [15:0] WeightBlue  = 16'd4732;

  // saturation gain, unsigned q4.8
  localparam logic [GainW-1:0] UnityGain = 12'd256;

  // channel selectors
  localparam logic [ChanW-1:0] ChanRed   = 2'd0;
  localparam logic [ChanW-1:0] ChanGreen = 2'd1;
  localparam logic [ChanW-1:0] ChanBlue  = 2'd2;
  localparam logic [ChanW-1:0] ChanAlpha = 2'd3;

  // request kind carried in tuser
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef logic [CompW-1:0] comp_t;

  // one classified request as it travels through the queue
  typedef struct packed {
    op_e                op;
    comp_t [NumChan-1:0] pix;      // index by channel selector
    logic [ChanW-1:0]   wr_chan;
    logic [IndexW-1:0]  wr_idx;
    comp_t              wr_val;
  } item_t;

endpackage

// ===== src/cdl_front.sv =====
// ----------------------------------------------------------------------------
// cdl_front
// Input side: takes requests off the slave stream and classifies them into
// pixel or table write items for the queue.
// ----------------------------------------------------------------------------
module cdl_front (
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [cdl_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                    s_axis_tuser,
  output logic                    push_o,
  output cdl_pkg::item_t          push_item_o,
  input  logic                    full_i
);
  import cdl_pkg::*;

  // request taken whenever the queue has room
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // unpack the fields and classify
  always_comb begin
    push_item_o                = '0;
    push_item_o.pix[ChanRed]   = s_axis_tdata[7:0];
    push_item_o.pix[ChanGreen] = s_axis_tdata[15:8];
    push_item_o.pix[ChanBlue]  = s_axis_tdata[23:16];
    push_item_o.pix[ChanAlpha] = s_axis_tdata[31:24];
    unique case (op_e'(s_axis_tuser))
      OP_WRITE: begin
        push_item_o.op      = OP_WRITE;
        push_item_o.wr_chan = s_axis_tdata[33:32];
        push_item_o.wr_idx  = s_axis_tdata[41:34];
        push_item_o.wr_val  = s_axis_tdata[49:42];
      end
      default: begin
        push_item_o.op = OP_PIXEL;
      end
    endcase
  end

endmodule

// ===== src/cdl_queue.sv =====
// ----------------------------------------------------------------------------
// cdl_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cdl_queue #(
  parameter int unsigned Depth = cdl_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cdl_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           valid_o,
  output cdl_pkg::item_t item_o,
  input  logic           pop_i
);
  import cdl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/cdl_back.sv =====
// ----------------------------------------------------------------------------
// cdl_back
// Execution side: table writes and lookups, luma, saturation and clamping,
// in a four stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module cdl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cdl_pkg::GainW-1:0]  gain_i,
  input  logic                       q_valid_i,
  input  cdl_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [cdl_pkg::OutDataW-1:0] m_axis_tdata
);
  import cdl_pkg::*;

  localparam int unsigned LumaW = 24;
  localparam int unsigned DiffW = 26;
  localparam int unsigned ProdW = 39;

  // stage valids and advance conditions
  logic out_v_q, s3_v_q, s2_v_q, s1_v_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic is_write, wr_en, rd_en;

  assign out_rdy = !out_v_q || m_axis_tready;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;

  // writes retire at once, pixels need room in the first stage
  assign is_write = (q_item_i.op == OP_WRITE);
  assign q_pop_o  = q_valid_i && (is_write || s1_rdy);
  assign wr_en    = q_valid_i && is_write;
  assign rd_en    = q_valid_i && !is_write && s1_rdy;

  // stage 1: per channel tables, registered read
  comp_t s1_chan_q [NumChan];

  for (genvar c = 0; c < NumChan; c++) begin : g_tbl
    comp_t mem_q [TableDepth];
    always_ff @(posedge clk_i) begin
      if (wr_en && (q_item_i.wr_chan == ChanW'(c))) begin
        mem_q[q_item_i.wr_idx] <= q_item_i.wr_val;
      end
      if (rd_en) begin
        s1_chan_q[c] <= mem_q[q_item_i.pix[c]];
      end
    end
  end

  // stage 2: luma
  logic [LumaW-1:0] luma_d, s2_luma_q;
  comp_t            s2_chan_q [NumChan];

  assign luma_d = LumaW'(WeightRed)   * LumaW'(s1_chan_q[ChanRed])
                + LumaW'(WeightGreen) * LumaW'(s1_chan_q[ChanGreen])
                + LumaW'(WeightBlue)  * LumaW'(s1_chan_q[ChanBlue]);

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_luma_q <= luma_d;
      s2_chan_q <= s1_chan_q;
    end
  end

  // stage 3: gain times colour difference from luma
  logic signed [GainW:0]   gain_s;
  logic signed [DiffW-1:0] diff_s [3];
  logic signed [ProdW-1:0] prod_d [3];
  logic signed [ProdW-1:0] s3_prod_q [3];
  logic [LumaW-1:0]        s3_luma_q;
  comp_t                   s3_chan_q [NumChan];

  assign gain_s = $signed({1'b0, gain_i});

  for (genvar c = 0; c < 3; c++) begin : g_prod
    assign diff_s[c] = $signed({2'b00, s2_chan_q[c], 16'h0000})
                     - $signed({2'b00, s2_luma_q});
    assign prod_d[c] = gain_s * diff_s[c];
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_prod_q <= prod_d;
      s3_luma_q <= s2_luma_q;
      s3_chan_q <= s2_chan_q;
    end
  end

  // stage 4: add luma back, clamp, unity bypass, output register
  logic signed [ProdW-1:0] sum_s [3];
  comp_t                   res_d [NumChan];
  comp_t                   out_q [NumChan];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_s[c] = $signed({7'b0, s3_luma_q, 8'h00}) + s3_prod_q[c];
      if (gain_i == UnityGain) begin
        res_d[c] = s3_chan_q[c];
      end else if (sum_s[c][ProdW-1]) begin
        res_d[c] = '0;
      end else if (|sum_s[c][ProdW-2:32]) begin
        res_d[c] = '1;
      end else begin
        res_d[c] = sum_s[c][31:24];
      end
    end
    res_d[ChanAlpha] = s3_chan_q[ChanAlpha];
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_v_q) begin
      out_q <= res_d;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= rd_en;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q[ChanAlpha], out_q[ChanBlue], out_q[ChanGreen], out_q[ChanRed]};

endmodule

// ===== src/cdl_lut_saturation_pixel.sv =====
// ----------------------------------------------------------------------------
// cdl_lut_saturation_pixel
// RGBA8 colour correction: per channel lookup tables followed by a
// Rec.709 luma based saturation stage.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: tuser low carries a pixel, tuser high a table write.
//   Each pixel channel is mapped through its own 256 entry table, then
//   red, green and blue are pushed away from or towards luma by the gain.
//   Tables must be written before the entries are looked up; their
//   contents are undefined after reset.
//   Config channel: one 12 bit gain in unsigned q4.8, reset value 256,
//   which leaves mapped colours unchanged. Write it only while idle.
//   Throughput: one request per cycle while the master stream is not
//   stalled, pixels and table writes alike. A pixel passes through the
//   queue, table read, luma, product and clamp registers to the output.
//   Table writes give no output and land in request order.
//   A stall on the master stream fills the four pipeline registers and
//   then the input queue; tready drops only once the queue is full.
//   Reset empties the queue and pipeline and restores the gain.
// ----------------------------------------------------------------------------
module cdl_lut_saturation_pixel #(
  parameter int unsigned QueueDepth = cdl_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: red_in, green_in, blue_in, alpha_in, table_channel,
  //        table_index, table_value, zero pad
  input  logic [cdl_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind
  input  logic                         s_axis_tuser,
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: red_out, green_out, blue_out, alpha_out
  output logic [cdl_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cdl_pkg::GainW-1:0]    cfg_data_i
);
  import cdl_pkg::*;

  logic             push, full, q_valid, q_pop;
  item_t            push_item, q_item;
  logic [GainW-1:0] gain_q;

  // gain register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= UnityGain;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  cdl_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  cdl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  cdl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_i        (gain_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
